FILE: sv/brb_pkg.sv
// Shared constants and codes for the byte ring buffer.
package brb_pkg;

    // Storage geometry
    localparam int DEPTH   = 1024;
    localparam int MAX_GET = 64;
    localparam int PTR_W   = $clog2(DEPTH);

    // Field widths
    localparam int ACT_W  = 2;
    localparam int BYTE_W = 8;
    localparam int GET_W  = 7;
    localparam int SIZE_W = 11;
    localparam int USED_W = 10;
    localparam int CNT_W  = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Smallest legal ring size
    localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd2;

endpackage

FILE: sv/brb_if.sv
// Valid/ready channel interfaces for the byte ring buffer request and result words.
interface brb_in_if;
    import brb_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [BYTE_W-1:0]   data_byte;
    logic                burst_end;
    logic [GET_W-1:0]    get_count;

    modport source (output valid, action, data_byte, burst_end, get_count, input ready);
    modport sink   (input valid, action, data_byte, burst_end, get_count, output ready);
endinterface

interface brb_out_if;
    import brb_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                out_last;
    logic                put_stored;
    logic [USED_W-1:0]   used_count;
    logic [USED_W-1:0]   free_count;
    logic [CNT_W-1:0]    overflow_total;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, out_byte, out_valid, out_last, put_stored, used_count,
                    free_count, overflow_total, is_empty, is_full, input ready);
    modport sink   (input valid, out_byte, out_valid, out_last, put_stored, used_count,
                    free_count, overflow_total, is_empty, is_full, output ready);
endinterface

FILE: sv/byte_ring_buffer.sv
// Byte ring buffer: one-port byte store with pointer, overflow and status logic.
// A result word passes through the pending stage and the output register after its request
// word is accepted. A get streams its bytes one byte per cycle while the output is not stalled,
//   set by the single read port of the byte store; no new request is taken until it ends.
// Reset: pointers, overflow counter and burst flag go to zero and the ring size to 1024;
//   the byte store is not cleared, so the block is ready in the first cycle after reset.
module byte_ring_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    brb_in_if.sink                      i_in,
    brb_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [brb_pkg::SIZE_W-1:0]  i_cfg_data
);
    import brb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_GET  = 2'b10
    } t_state;

    // Byte store
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_mem_q;
    logic              mem_we;
    logic              mem_re;

    // Control state
    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [CNT_W-1:0]  r_ovf, n_ovf;
    logic              r_dropped, n_dropped;
    logic [GET_W-1:0]  r_left, n_left;

    // Pending stage: result word waiting for its read data
    logic              r_pend, n_pend;
    logic              r_p_valid, n_p_valid;
    logic              r_p_last, n_p_last;
    logic              r_p_stored, n_p_stored;

    // Output register
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_bvalid;
    logic              r_o_last;
    logic              r_o_stored;
    logic [USED_W-1:0] r_o_used;
    logic [USED_W-1:0] r_o_free;
    logic [CNT_W-1:0]  r_o_ovf;
    logic              r_o_empty;
    logic              r_o_full;

    logic              adv;
    logic              accept;
    logic [SIZE_W-1:0] used_w;
    logic [SIZE_W-1:0] free_w;
    logic [GET_W-1:0]  get_cnt;
    logic [GET_W-1:0]  get_n;
    logic [SIZE_W-1:0] cfg_size;

    // Step a pointer around the configured ring
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(p) + SIZE_W'(1);
        if (nxt >= size) begin
            return '0;
        end
        return nxt[PTR_W-1:0];
    endfunction

    // Occupancy from the current pointers
    always_comb begin
        if (r_wp >= r_rp) begin
            used_w = SIZE_W'(r_wp) - SIZE_W'(r_rp);
        end else begin
            used_w = r_size - (SIZE_W'(r_rp) - SIZE_W'(r_wp));
        end
        free_w = r_size - used_w - SIZE_W'(1);
    end

    // Clamp the request count, then bound it by what is stored
    always_comb begin
        if (i_in.get_count > GET_W'(MAX_GET)) begin
            get_cnt = GET_W'(MAX_GET);
        end else begin
            get_cnt = i_in.get_count;
        end
        if (used_w < SIZE_W'(get_cnt)) begin
            get_n = used_w[GET_W-1:0];
        end else begin
            get_n = get_cnt;
        end
    end

    // Clamp a written ring size
    always_comb begin
        if (i_cfg_data < MIN_SIZE) begin
            cfg_size = MIN_SIZE;
        end else if (i_cfg_data > SIZE_W'(DEPTH)) begin
            cfg_size = SIZE_W'(DEPTH);
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // Output stage advances when empty or when its word is taken
    assign adv          = !r_o_valid || o_out.ready;
    assign i_in.ready   = (r_state == ST_IDLE) && adv;
    assign accept       = i_in.valid && i_in.ready;

    // Next-state logic; a write and a read never share a cycle, so no forwarding
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_size     = r_size;
        n_ovf      = r_ovf;
        n_dropped  = r_dropped;
        n_left     = r_left;
        n_pend     = r_pend && !adv;
        n_p_valid  = r_p_valid;
        n_p_last   = r_p_last;
        n_p_stored = r_p_stored;
        mem_we     = 1'b0;
        mem_re     = 1'b0;

        if (accept) begin
            n_pend     = 1'b1;
            n_p_valid  = 1'b0;
            n_p_last   = 1'b1;
            n_p_stored = 1'b0;
            case (i_in.action)
                ACT_PUT: begin
                    if (free_w != '0) begin
                        mem_we     = 1'b1;
                        n_wp       = ptr_inc(r_wp, r_size);
                        n_p_stored = 1'b1;
                    end else if (!r_dropped) begin
                        if (r_ovf != '1) begin
                            n_ovf = r_ovf + CNT_W'(1);
                        end
                        n_dropped = 1'b1;
                    end
                    if (i_in.burst_end) begin
                        n_dropped = 1'b0;
                    end
                end
                ACT_GET: begin
                    if (get_n != '0) begin
                        mem_re    = 1'b1;
                        n_rp      = ptr_inc(r_rp, r_size);
                        n_p_valid = 1'b1;
                        n_p_last  = (get_n == GET_W'(1));
                        n_left    = get_n - GET_W'(1);
                        if (get_n != GET_W'(1)) begin
                            n_state = ST_GET;
                        end
                    end
                end
                ACT_CLEAR: begin
                    n_wp      = '0;
                    n_rp      = '0;
                    n_ovf     = '0;
                    n_dropped = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_GET && adv) begin
            // Stream the next byte of the get
            mem_re     = 1'b1;
            n_rp       = ptr_inc(r_rp, r_size);
            n_pend     = 1'b1;
            n_p_valid  = 1'b1;
            n_p_stored = 1'b0;
            n_p_last   = (r_left == GET_W'(1));
            n_left     = r_left - GET_W'(1);
            if (r_left == GET_W'(1)) begin
                n_state = ST_IDLE;
            end
        end

        // Size write restarts the ring and keeps the counter
        if (i_cfg_we) begin
            n_size    = cfg_size;
            n_wp      = '0;
            n_rp      = '0;
            n_dropped = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_size    <= SIZE_W'(DEPTH);
            r_ovf     <= '0;
            r_dropped <= 1'b0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_size    <= n_size;
            r_ovf     <= n_ovf;
            r_dropped <= n_dropped;
            r_left    <= n_left;
            r_pend    <= n_pend;
            if (adv) begin
                r_o_valid <= r_pend;
            end
        end
    end

    // Pending flags
    always_ff @(posedge i_clk) begin
        r_p_valid  <= n_p_valid;
        r_p_last   <= n_p_last;
        r_p_stored <= n_p_stored;
    end

    // Byte store access; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_in.data_byte;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    // Load the output word with status after the pending word's update
    always_ff @(posedge i_clk) begin
        if (adv && r_pend) begin
            r_o_byte   <= r_p_valid ? r_mem_q : '0;
            r_o_bvalid <= r_p_valid;
            r_o_last   <= r_p_last;
            r_o_stored <= r_p_stored;
            r_o_used   <= used_w[USED_W-1:0];
            r_o_free   <= free_w[USED_W-1:0];
            r_o_ovf    <= r_ovf;
            r_o_empty  <= (used_w == '0);
            r_o_full   <= (free_w == '0);
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.out_byte       = r_o_byte;
    assign o_out.out_valid      = r_o_bvalid;
    assign o_out.out_last       = r_o_last;
    assign o_out.put_stored     = r_o_stored;
    assign o_out.used_count     = r_o_used;
    assign o_out.free_count     = r_o_free;
    assign o_out.overflow_total = r_o_ovf;
    assign o_out.is_empty       = r_o_empty;
    assign o_out.is_full        = r_o_full;

`ifndef SYNTHESIS
    // A stalled pending word keeps its flags and, for a byte word, its read data
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !adv) |=> (r_pend && $stable(r_p_last) &&
                              (!r_p_valid || $stable(r_mem_q))))
        else $error("pending word lost while output stalled");

    // A streaming get always has bytes left to read
    a_get_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GET) |-> (r_left != '0))
        else $error("get stream with no bytes left");

    // Occupancy stays below the ring size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_w < r_size)
        else $error("occupancy reached ring size");

    // The store port never writes and reads in one cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("byte store written and read together");
`endif

endmodule

FILE: tb/byte_ring_buffer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_buffer: random request traffic against a ring model.
module byte_ring_buffer_tb;
    import brb_pkg::*;

    // Action code with no effect on the ring
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    localparam int  HOLD_CYCLES  = 400;
    localparam int  QUIET_LIMIT  = 3000;
    localparam int  MAX_REPORTS  = 10;
    localparam int  DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic              burst_end;
        logic [GET_W-1:0]  get_count;
    } t_ring_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
        logic              put_stored;
        logic [USED_W-1:0] used_count;
        logic [USED_W-1:0] free_count;
        logic [CNT_W-1:0]  overflow_total;
        logic              is_empty;
        logic              is_full;
    } t_ring_status;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_data;

    brb_in_if  in_if ();
    brb_out_if out_if ();

    byte_ring_buffer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Request words waiting to be sent, status words waiting to arrive
    t_ring_req    req_q[$];
    t_ring_status status_q[$];

    // Ring model state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int                ring_wr;
    int                ring_rd;
    int                ring_len;
    logic [CNT_W-1:0]  lost_bursts;
    logic              burst_lost;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_asked;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int err_cnt;

    // Toggle the clock
    always #4 i_clk = ~i_clk;

    function automatic int ring_used();
        return (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_len - (ring_rd - ring_wr);
    endfunction

    function automatic void push_status(logic [BYTE_W-1:0] b, logic v, logic l, logic s);
        t_ring_status st;
        int           used;
        int           room;
        used = ring_used();
        room = ring_len - used - 1;
        st.out_byte       = b;
        st.out_valid      = v;
        st.out_last       = l;
        st.put_stored     = s;
        st.used_count     = used[USED_W-1:0];
        st.free_count     = room[USED_W-1:0];
        st.overflow_total = lost_bursts;
        st.is_empty       = (used == 0);
        st.is_full        = (room == 0);
        status_q.push_back(st);
    endfunction

    // Apply one accepted request to the ring model and queue the status words it causes
    function automatic void ring_apply(t_ring_req r);
        int   n;
        logic stored;
        logic [BYTE_W-1:0] b;
        case (r.action)
            ACT_PUT: begin
                stored = 1'b0;
                if (ring_len - ring_used() - 1 > 0) begin
                    ring_mem[ring_wr[PTR_W-1:0]] = r.data_byte;
                    ring_wr = (ring_wr + 1 >= ring_len) ? 0 : ring_wr + 1;
                    stored = 1'b1;
                end else if (!burst_lost) begin
                    // count each burst that loses bytes once, saturating
                    if (lost_bursts != '1)
                        lost_bursts = lost_bursts + 1'b1;
                    burst_lost = 1'b1;
                end
                if (r.burst_end)
                    burst_lost = 1'b0;
                push_status('0, 1'b0, 1'b1, stored);
            end
            ACT_GET: begin
                n = (r.get_count > MAX_GET) ? MAX_GET : int'(r.get_count);
                if (ring_used() < n)
                    n = ring_used();
                if (n == 0) begin
                    push_status('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        b = ring_mem[ring_rd[PTR_W-1:0]];
                        ring_rd = (ring_rd + 1 >= ring_len) ? 0 : ring_rd + 1;
                        push_status(b, 1'b1, i == n - 1, 1'b0);
                    end
                end
            end
            ACT_CLEAR: begin
                ring_wr     = 0;
                ring_rd     = 0;
                lost_bursts = '0;
                burst_lost  = 1'b0;
                push_status('0, 1'b0, 1'b1, 1'b0);
            end
            default: begin
                push_status('0, 1'b0, 1'b1, 1'b0);
            end
        endcase
    endfunction

    function automatic void add_req(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b, logic e,
                                    logic [GET_W-1:0] n);
        t_ring_req r;
        r.action    = act;
        r.data_byte = b;
        r.burst_end = e;
        r.get_count = n;
        req_q.push_back(r);
    endfunction

    // Request driver: hold a word until accepted, then send the next one or idle
    always @(posedge i_clk) begin : drive_p
        t_ring_req nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                ring_apply({in_if.action, in_if.data_byte, in_if.burst_end, in_if.get_count});
            if (!in_if.valid || in_if.ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = req_q.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.action    <= nxt.action;
                    in_if.data_byte <= nxt.data_byte;
                    in_if.burst_end <= nxt.burst_end;
                    in_if.get_count <= nxt.get_count;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_served  <= 0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            out_if.ready <= 1'b0;
            hold_served  <= hold_asked;
            hold_left    <= HOLD_CYCLES;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin : check_p
        t_ring_status got;
        t_ring_status want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.out_byte, out_if.out_valid, out_if.out_last, out_if.put_stored,
                   out_if.used_count, out_if.free_count, out_if.overflow_total,
                   out_if.is_empty, out_if.is_full};
            if (status_q.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("unexpected result word at %0t", $realtime);
                err_cnt <= err_cnt + 1;
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    if (err_cnt < MAX_REPORTS) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp byte=%h v=%b l=%b st=%b used=%0d free=%0d ovf=%0d e=%b f=%b",
                                 want.out_byte, want.out_valid, want.out_last, want.put_stored,
                                 want.used_count, want.free_count, want.overflow_total,
                                 want.is_empty, want.is_full);
                        $display("  got byte=%h v=%b l=%b st=%b used=%0d free=%0d ovf=%0d e=%b f=%b",
                                 got.out_byte, got.out_valid, got.out_last, got.put_stored,
                                 got.used_count, got.free_count, got.overflow_total,
                                 got.is_empty, got.is_full);
                    end
                    err_cnt <= err_cnt + 1;
                end
            end
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("watchdog expired at %0t", $realtime);
        $display("TB_ERROR");
        $finish;
    end

    // Wait until every request is sent and every result word has arrived
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (req_q.size() != 0 || in_if.valid || status_q.size() != 0);
    endtask

    // Write the ring size while the block is idle and mirror it in the model
    task automatic set_ring_size(input logic [SIZE_W-1:0] v);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        #1;
        if (v < MIN_SIZE)
            ring_len = int'(MIN_SIZE);
        else if (v > DEPTH)
            ring_len = DEPTH;
        else
            ring_len = int'(v);
        ring_wr    = 0;
        ring_rd    = 0;
        burst_lost = 1'b0;
    endtask

    // Queue random traffic: mostly put bursts and gets, some clears and noise
    task automatic queue_traffic(input int n_items);
        int cnt;
        int pick;
        int len;
        cnt = 0;
        while (cnt < n_items) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_req(ACT_PUT, BYTE_W'($urandom_range(255)),
                            (i == len - 1) && ($urandom_range(99) < 80),
                            GET_W'($urandom_range(127)));
                cnt += len;
            end else if (pick < 82) begin
                add_req(ACT_GET, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                        GET_W'(($urandom_range(99) < 85) ? $urandom_range(1, MAX_GET)
                                                         : $urandom_range(127)));
                cnt++;
            end else if (pick < 90) begin
                add_req(ACT_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                        GET_W'($urandom_range(127)));
                cnt++;
            end else begin
                add_req(ACT_NOP, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                        GET_W'($urandom_range(127)));
            end
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.action    = ACT_PUT;
        in_if.data_byte = '0;
        in_if.burst_end = 1'b0;
        in_if.get_count = '0;
        out_if.ready    = 1'b0;
        src_idle_pct    = 34;
        snk_idle_pct    = 34;
        hold_asked      = 0;
        quiet_cycles    = 0;
        err_cnt         = 0;
        ring_wr         = 0;
        ring_rd         = 0;
        ring_len        = DEPTH;
        lost_bursts     = '0;
        burst_lost      = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Directed: empty gets, byte extremes, zero and oversized counts, ignored action, clear
        add_req(ACT_GET, 8'h00, 1'b0, 7'd5);
        add_req(ACT_PUT, 8'h00, 1'b0, 7'd0);
        add_req(ACT_PUT, 8'hFF, 1'b0, 7'd127);
        add_req(ACT_PUT, 8'hA5, 1'b1, 7'd0);
        add_req(ACT_GET, 8'hFF, 1'b1, 7'd0);
        add_req(ACT_GET, 8'h00, 1'b0, 7'd127);
        add_req(ACT_NOP, 8'hFF, 1'b1, 7'd127);
        add_req(ACT_PUT, 8'h5A, 1'b0, 7'd0);
        add_req(ACT_CLEAR, 8'h00, 1'b0, 7'd0);
        add_req(ACT_GET, 8'h00, 1'b0, 7'd1);
        add_req(ACT_GET, 8'h00, 1'b0, 7'd64);

        // Smallest ring from a size below range: one byte of room, burst drop counting
        set_ring_size(11'd0);
        add_req(ACT_PUT, 8'h11, 1'b0, 7'd0);
        add_req(ACT_PUT, 8'h22, 1'b0, 7'd0);
        add_req(ACT_PUT, 8'h33, 1'b1, 7'd0);
        add_req(ACT_PUT, 8'h44, 1'b1, 7'd0);
        add_req(ACT_GET, 8'h00, 1'b0, 7'd64);
        add_req(ACT_PUT, 8'h55, 1'b1, 7'd0);
        add_req(ACT_CLEAR, 8'h00, 1'b0, 7'd0);
        add_req(ACT_GET, 8'h00, 1'b0, 7'd1);

        // Count one drop per single-byte burst on a full ring, no idling on either side
        set_ring_size(11'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        add_req(ACT_PUT, 8'hC3, 1'b0, 7'd0);
        for (int i = 0; i < 20; i++)
            add_req(ACT_PUT, BYTE_W'($urandom_range(255)), 1'b1, GET_W'($urandom_range(127)));
        add_req(ACT_GET, 8'h00, 1'b0, 7'd2);
        add_req(ACT_CLEAR, 8'h00, 1'b0, 7'd0);
        drain();
        src_idle_pct = 34;
        snk_idle_pct = 34;

        // Largest ring from a size above range; hold off results while puts keep coming
        set_ring_size(11'd2047);
        hold_asked = hold_asked + 1;
        for (int i = 0; i < 40; i++)
            add_req(ACT_PUT, BYTE_W'($urandom_range(255)), i == 39, GET_W'($urandom_range(127)));
        for (int i = 0; i < 2; i++)
            add_req(ACT_GET, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 7'd64);
        queue_traffic(80);

        set_ring_size(11'd1024);
        queue_traffic(40);
        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_traffic(60);
        drain();
        src_idle_pct = 34;
        snk_idle_pct = 34;

        set_ring_size(11'd3);
        queue_traffic(30);

        set_ring_size(SIZE_W'($urandom_range(4, 40)));
        queue_traffic(30);

        set_ring_size(SIZE_W'($urandom_range(2, 2047)));
        queue_traffic(30);

        // Let stray result words show up before the verdict
        drain();
        repeat (20) @(posedge i_clk);
        #1;
        if (status_q.size() != 0) begin
            $display("%0d result words never arrived", status_q.size());
            err_cnt = err_cnt + 1;
        end
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
